// ===== rtl/core/sorted_key_index_search_defines.svh =====
// Assertion macros for the sorted key index search block.
// Included by the top level, the one RTL file with assertions; no other dependencies.
`ifndef SORTED_KEY_INDEX_SEARCH_DEFINES_SVH
`define SORTED_KEY_INDEX_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// Check a plain condition at every clock edge outside reset.
`define SKS_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sks assertion failed");

// Check that a trigger implies a consequence in the same cycle.
`define SKS_ASSERT_IMP(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("sks implication failed");

`else

`define SKS_ASSERT(label, clk, rst_n, cond)
`define SKS_ASSERT_IMP(label, clk, rst_n, trig, cons)

`endif

`endif

// ===== rtl/core/sks_pkg.sv =====
// Shared types, codes and helper functions for the sorted key index search block.
// No dependencies; used by the key compare, the top level and the testbench.
`default_nettype none

package sks_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned LEN_W = 4;
  localparam int unsigned LOC_W = 64;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  typedef struct packed {
    op_e                       op;
    logic [KEY_W-1:0]          key_bytes;
    logic [LEN_W-1:0]          key_length;
    logic signed [LOC_W-1:0]   value_location;
  } in_t;

  typedef struct packed {
    status_e                   status;
    logic signed [LOC_W-1:0]   found_location;
    logic                      in_range;
  } out_t;

  // Keep the first n bytes of a key, first byte in the top bits.
  function automatic logic [KEY_W-1:0] keep_mask(input logic [LEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (LEN_W'(i) < n) begin
        m[KEY_W-1-8*i -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sks_entry_ram.sv =====
// Entry memory: one write port, one registered read port, no reset.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module sks_entry_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 132
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/sks_key_cmp.sv =====
// Key order compare: probe key against one stored key, bytewise over the
// common length, shorter key smaller on a tie. Depends on sks_pkg.
`default_nettype none

module sks_key_cmp (
  input  logic [sks_pkg::KEY_W-1:0] probe_key_i,
  input  logic [sks_pkg::LEN_W-1:0] probe_len_i,
  input  logic [sks_pkg::KEY_W-1:0] entry_key_i,
  input  logic [sks_pkg::LEN_W-1:0] entry_len_i,
  output sks_pkg::cmp_e             order_o
);

  logic [sks_pkg::LEN_W-1:0] common_len;
  logic [sks_pkg::KEY_W-1:0] mask;
  logic [sks_pkg::KEY_W-1:0] a;
  logic [sks_pkg::KEY_W-1:0] b;

  always_comb begin
    common_len = (probe_len_i < entry_len_i) ? probe_len_i : entry_len_i;
    mask       = sks_pkg::keep_mask(common_len);
    a          = probe_key_i & mask;
    b          = entry_key_i & mask;
    // first differing byte decides, which is a plain magnitude compare
    if (a < b) begin
      order_o = sks_pkg::CMP_LT;
    end else if (a > b) begin
      order_o = sks_pkg::CMP_GT;
    end else if (probe_len_i < entry_len_i) begin
      order_o = sks_pkg::CMP_LT;
    end else if (probe_len_i > entry_len_i) begin
      order_o = sks_pkg::CMP_GT;
    end else begin
      order_o = sks_pkg::CMP_EQ;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_index_search.sv =====
// Top level of the sorted key index search block: sequencer, entry count and
// output register. Depends on sks_pkg, sks_entry_ram, sks_key_cmp and the defines header.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_i  (sks_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i| out_o (sks_pkg::out_t)
//
// Every transaction goes through accept, dispatch and result; append, clear, the
// unused op and a lookup on an empty table take no other step. A lookup on a filled
// table adds, after dispatch, reads of the first and then the last entry for the
// range check, one read per binary search probe (at most ceil(log2(MAX_ENTRIES))
// probes, 10 at 1024 entries) and a final check at lo, skipped when a probe hits;
// the single entry memory port serves one read at a time. Reset clears the entry
// count, the sequencer and the output valid flag only; the memory is never cleared.
// The input side is stalled while a transaction is in flight; a finished result
// waits in its own register until the output slot is free, so a stalled output
// holds the sequencer in its result state and nothing is lost.
`default_nettype none
`include "sorted_key_index_search_defines.svh"

module sorted_key_index_search #(
  parameter int unsigned MAX_ENTRIES   = 1024,
  parameter int unsigned MAX_KEY_BYTES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sks_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sks_pkg::out_t  out_o
);

  localparam int unsigned AW      = $clog2(MAX_ENTRIES);
  localparam int unsigned CW      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW      = CW + 1;
  localparam int unsigned KW      = 8 * MAX_KEY_BYTES;
  localparam int unsigned ENTRY_W = sks_pkg::LOC_W + sks_pkg::LEN_W + KW;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_FIRST    = 7'b0000100,
    S_LAST     = 7'b0001000,
    S_SEARCH   = 7'b0010000,
    S_FINAL    = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Latched transaction, key already clamped and masked.
  sks_pkg::op_e                    op_q;
  logic [sks_pkg::KEY_W-1:0]       key_q;
  logic [sks_pkg::LEN_W-1:0]       len_q;
  logic signed [sks_pkg::LOC_W-1:0] val_q;

  logic [CW-1:0]        count_q, count_d;
  logic signed [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]        mid_q, mid_d;
  logic                 ge_first_q, ge_first_d;
  sks_pkg::out_t        res_q, res_d;
  sks_pkg::out_t        out_q;
  logic                 out_valid_q;

  logic                 in_accept;
  logic                 out_load;
  logic [sks_pkg::LEN_W-1:0] in_len;

  // Memory port and read-back fields.
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic [sks_pkg::KEY_W-1:0] rd_key;
  logic [sks_pkg::LEN_W-1:0] rd_len;
  logic signed [sks_pkg::LOC_W-1:0] rd_loc;
  sks_pkg::cmp_e        order;

  logic [CW-1:0]        last_idx;
  logic signed [IW-1:0] nlo, nhi, nmid;
  logic                 do_step;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  // Clamp long keys and drop stray bytes past the key length.
  assign in_len = (in_i.key_length > sks_pkg::LEN_W'(MAX_KEY_BYTES)) ?
                  sks_pkg::LEN_W'(MAX_KEY_BYTES) : in_i.key_length;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_i.op;
      len_q <= in_len;
      key_q <= in_i.key_bytes & sks_pkg::keep_mask(in_len);
      val_q <= in_i.value_location;
    end
  end

  // Entry layout: {value location, length, key bytes}.
  assign mem_wdata = {val_q, len_q, key_q[sks_pkg::KEY_W-1 -: KW]};
  assign rd_loc    = mem_rdata[ENTRY_W-1 -: sks_pkg::LOC_W];
  assign rd_len    = mem_rdata[KW +: sks_pkg::LEN_W];

  always_comb begin
    rd_key = '0;
    rd_key[sks_pkg::KEY_W-1 -: KW] = mem_rdata[KW-1:0];
  end

  // One access per cycle and one transaction at a time: the sequencer itself
  // keeps a write and a read of the same entry from overlapping.
  sks_entry_ram #(
    .AW (AW),
    .DW (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sks_key_cmp u_cmp (
    .probe_key_i (key_q),
    .probe_len_i (len_q),
    .entry_key_i (rd_key),
    .entry_len_i (rd_len),
    .order_o     (order)
  );

  assign last_idx = count_q - CW'(1);

  // Narrow the search window after a probe at mid; outside a probe keep it.
  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (state_q == S_SEARCH) begin
      if (order == sks_pkg::CMP_LT) begin
        nhi = $signed(IW'(mid_q)) - IW'(1);
      end else begin
        nlo = $signed(IW'(mid_q)) + IW'(1);
      end
    end
    nmid = nlo + ((nhi - nlo) >>> 1);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    ge_first_d = ge_first_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    do_step    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d   = '0;
        state_d = S_RESULT;
        case (op_q)
          sks_pkg::OP_APPEND: begin
            if (count_q == CW'(MAX_ENTRIES)) begin
              res_d.status = sks_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          sks_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          sks_pkg::OP_LOOKUP: begin
            res_d.status = sks_pkg::ST_MISS;
            if (count_q != '0) begin
              // Read the first entry for the lower range bound.
              mem_re  = 1'b1;
              lo_d    = '0;
              hi_d    = $signed(IW'(count_q)) - IW'(1);
              state_d = S_FIRST;
            end
          end
          default: begin
            // Unused op: report ok with empty fields.
          end
        endcase
      end
      S_FIRST: begin
        ge_first_d = (order != sks_pkg::CMP_LT);
        mem_re     = 1'b1;
        mem_raddr  = last_idx[AW-1:0];
        state_d    = S_LAST;
      end
      S_LAST: begin
        res_d.in_range = ge_first_q && (order != sks_pkg::CMP_GT);
        do_step        = 1'b1;
      end
      S_SEARCH: begin
        if (order == sks_pkg::CMP_EQ) begin
          res_d.status         = sks_pkg::ST_OK;
          res_d.found_location = rd_loc;
          state_d              = S_RESULT;
        end else begin
          do_step = 1'b1;
        end
      end
      S_FINAL: begin
        if (order == sks_pkg::CMP_EQ) begin
          res_d.status         = sks_pkg::ST_OK;
          res_d.found_location = rd_loc;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Issue the next probe: mid while the window is open, else the final check at lo.
    if (do_step) begin
      lo_d   = nlo;
      hi_d   = nhi;
      mem_re = 1'b1;
      if (nlo < nhi) begin
        mid_d     = nmid[AW-1:0];
        mem_raddr = nmid[AW-1:0];
        state_d   = S_SEARCH;
      end else begin
        mem_raddr = nlo[AW-1:0];
        state_d   = S_FINAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    ge_first_q <= ge_first_d;
    res_q      <= res_d;
  end

  // Output register: load a finished result, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SKS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_ENTRIES))
  `SKS_ASSERT_IMP(a_search_open, clk_i, rst_ni, state_q == S_SEARCH, lo_q < hi_q)
  `SKS_ASSERT_IMP(a_final_in_table, clk_i, rst_ni, state_q == S_FINAL, (lo_q >= 0) && (lo_q < $signed(IW'(count_q))))
  `SKS_ASSERT_IMP(a_write_not_full, clk_i, rst_ni, mem_we, count_q < CW'(MAX_ENTRIES))

endmodule

`default_nettype wire

// ===== tb/tb_sorted_key_index_search.sv =====
// Self-checking testbench for sorted_key_index_search: drives append, clear, lookup and
// unused-op transactions, predicts every result from an in-bench copy of the key table.
// Depends on sks_pkg and the sorted_key_index_search RTL.

module tb_sorted_key_index_search;
  import sks_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned KEY_BYTES      = 8;
  localparam int unsigned LEN_MAX        = 15;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam logic signed [63:0] LOC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] LOC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  // Idle and stall rates in percent; the main sequence changes them per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Shadow copy of the key table, updated at each accepted input transaction.
  logic [63:0]        tbl_key [TABLE_DEPTH];
  logic [3:0]         tbl_len [TABLE_DEPTH];
  logic signed [63:0] tbl_loc [TABLE_DEPTH];
  int unsigned        tbl_fill = 0;

  // Results owed by the block, oldest first.
  out_t results_due[$];

  int unsigned items_sent   = 0;
  int unsigned n_append_ok  = 0;
  int unsigned n_full       = 0;
  int unsigned n_lookup     = 0;
  int unsigned n_hit        = 0;
  int unsigned n_clear      = 0;
  int unsigned n_unused     = 0;
  int unsigned n_checked    = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;

  sorted_key_index_search #(
    .MAX_ENTRIES  (TABLE_DEPTH),
    .MAX_KEY_BYTES(KEY_BYTES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Key arithmetic
  // ---------------------------------------------------------------------------

  // Mask covering the first len bytes of a key (first byte in the top bits).
  function automatic logic [63:0] byte_mask(input int unsigned len);
    return (len == 0) ? 64'd0 : ~({64{1'b1}} >> (8 * len));
  endfunction

  // Order of key a against key b: bytewise unsigned over the common length,
  // then the shorter key is the smaller. Returns -1, 0 or 1.
  function automatic int key_compare(input logic [63:0] ka, input int unsigned la,
                                     input logic [63:0] kb, input int unsigned lb);
    int unsigned n;
    n = (la < lb) ? la : lb;
    for (int unsigned i = 0; i < n; i++) begin
      if (ka[63-8*i -: 8] != kb[63-8*i -: 8]) begin
        return (ka[63-8*i -: 8] < kb[63-8*i -: 8]) ? -1 : 1;
      end
    end
    if (la == lb) return 0;
    return (la < lb) ? -1 : 1;
  endfunction

  function automatic int probe_entry(input logic [63:0] key, input int unsigned len,
                                     input int idx);
    return key_compare(key, len, tbl_key[idx], tbl_len[idx]);
  endfunction

  // Apply one transaction to the shadow table and return the result it owes.
  function automatic out_t apply_table_op(input in_t item);
    out_t        res;
    int unsigned len;
    logic [63:0] key;
    int          lo;
    int          hi;
    int          mid;
    int          c;
    bit          hit;
    res    = '0;
    // Clamp long keys to the table's key width, drop stray bytes.
    len    = (item.key_length > KEY_BYTES) ? KEY_BYTES : item.key_length;
    key    = item.key_bytes & byte_mask(len);
    case (item.op)
      OP_APPEND: begin
        if (tbl_fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          tbl_key[tbl_fill] = key;
          tbl_len[tbl_fill] = 4'(len);
          tbl_loc[tbl_fill] = item.value_location;
          tbl_fill++;
          n_append_ok++;
        end
      end
      OP_CLEAR: begin
        tbl_fill = 0;
        n_clear++;
      end
      OP_LOOKUP: begin
        n_lookup++;
        if (tbl_fill == 0) begin
          res.status = ST_MISS;
        end else begin
          // Same probe order as the block: the first probe that matches wins,
          // whether or not the table is really sorted.
          lo  = 0;
          hi  = int'(tbl_fill) - 1;
          hit = 1'b0;
          while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            c   = probe_entry(key, len, mid);
            if (c == 0) begin
              hit = 1'b1;
              res.found_location = tbl_loc[mid];
            end else if (c < 0) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
          if (!hit && probe_entry(key, len, lo) == 0) begin
            hit = 1'b1;
            res.found_location = tbl_loc[lo];
          end
          res.status = hit ? ST_OK : ST_MISS;
          if (hit) n_hit++;
          res.in_range = (probe_entry(key, len, 0) >= 0) &&
                         (probe_entry(key, len, int'(tbl_fill) - 1) <= 0);
        end
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_t make_item(input op_e op, input logic [63:0] key,
                                    input logic [3:0] len, input logic signed [63:0] loc);
    in_t item;
    item.op             = op;
    item.key_bytes      = key;
    item.key_length     = len;
    item.value_location = loc;
    return item;
  endfunction

  // Favor bytes at the edges and the middle of the byte range so that prefixes and ties occur.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[63-8*i -: 8] = rand_byte();
    return k;
  endfunction

  function automatic logic signed [63:0] rand_loc();
    case ($urandom_range(0, 9))
      0:       return LOC_MIN;
      1:       return LOC_MAX;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic op_e pick_op();
    case ($urandom_range(0, 3))
      0:       return OP_APPEND;
      1:       return OP_CLEAR;
      2:       return OP_LOOKUP;
      default: return op_e'(OP_UNUSED);
    endcase
  endfunction

  // Keep the valid bytes of a key and fill the rest with random garbage.
  function automatic logic [63:0] with_stray(input logic [63:0] key, input int unsigned len);
    return (key & byte_mask(len)) | ({$urandom(), $urandom()} & ~byte_mask(len));
  endfunction

  // Length field for a key: a full-width key sometimes gets an oversized length.
  function automatic logic [3:0] length_code(input int unsigned len);
    if (len == KEY_BYTES && $urandom_range(0, 2) == 0) begin
      return 4'($urandom_range(KEY_BYTES, LEN_MAX));
    end
    return 4'(len);
  endfunction

  function automatic in_t noise_item();
    return make_item(pick_op(), {$urandom(), $urandom()},
                     4'($urandom_range(0, LEN_MAX)), rand_loc());
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: send one transaction, predict its result once accepted
  // ---------------------------------------------------------------------------

  task automatic send_item(input in_t item);
    // Idle at random before offering the transaction.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    // Hold valid and payload until an edge sees the stall low.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results_due.push_back(apply_table_op(item));
    items_sent++;
  endtask

  // Hold off new input until the block has returned everything it owes.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 6) send_item(noise_item());
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, check each result, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d location %0d in_range %0b",
                 $time, out_o.status, out_o.found_location, out_o.in_range);
        errors++;
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (out_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_o.status);
          errors++;
        end
        if (out_o.found_location !== want.found_location) begin
          $display("%0t: found_location mismatch, expected %0d, actual %0d",
                   $time, want.found_location, out_o.found_location);
          errors++;
        end
        if (out_o.in_range !== want.in_range) begin
          $display("%0t: in_range mismatch, expected %0b, actual %0b",
                   $time, want.in_range, out_o.in_range);
          errors++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, results_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, every op and the corner cases of the search, on tiny tables.
  task automatic test_directed_cases();
    // Lookup on the empty table after reset.
    send_item(make_item(OP_LOOKUP, 64'h4100_0000_0000_0000, 4'd1, '0));
    // Build an ordered table: empty key (stray bytes all set), "A", "AB" twice,
    // all-ones key. Locations hit both signed extremes.
    send_item(make_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, LOC_MIN));
    send_item(make_item(OP_APPEND, 64'h41FF_0000_0000_0000, 4'd1, 64'sd1));
    send_item(make_item(OP_APPEND, 64'h4142_0000_0000_0000, 4'd2, -64'sd1));
    send_item(make_item(OP_APPEND, 64'h4142_FFFF_FFFF_FFFF, 4'd2, 64'sd77));
    send_item(make_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, LOC_MAX));
    // Empty key with garbage, "A", duplicate "AB", long all-ones key.
    send_item(make_item(OP_LOOKUP, 64'h1234_5678_9ABC_DEF0, 4'd0, '0));
    send_item(make_item(OP_LOOKUP, 64'h41AA_5555_0000_0000, 4'd1, LOC_MAX));
    send_item(make_item(OP_LOOKUP, 64'h4142_0000_0000_0000, 4'd2, '0));
    send_item(make_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, '0));
    // Misses inside the range: "AC", "A\0" (between "A" and "AB"), "\0".
    send_item(make_item(OP_LOOKUP, 64'h4143_0000_0000_0000, 4'd2, '0));
    send_item(make_item(OP_LOOKUP, 64'h4100_FFFF_0000_0000, 4'd2, '0));
    send_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_0000, 4'd1, '0));
    // Unused op leaves the table alone.
    send_item(make_item(op_e'(OP_UNUSED), 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, LOC_MAX));
    // Clear, then lookup on the emptied table.
    send_item(make_item(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, LOC_MIN));
    send_item(make_item(OP_LOOKUP, 64'h4100_0000_0000_0000, 4'd1, '0));
    // Single entry "M": below, above and on it.
    send_item(make_item(OP_APPEND, 64'h4D00_0000_0000_0000, 4'd1, 64'sd5));
    send_item(make_item(OP_LOOKUP, 64'h4100_0000_0000_0000, 4'd1, '0));
    send_item(make_item(OP_LOOKUP, 64'h5A00_0000_0000_0000, 4'd1, '0));
    send_item(make_item(OP_LOOKUP, 64'h4D00_0000_0000_0000, 4'd1, '0));
    // Out-of-order append "B" after "M": the search reports what it probes.
    send_item(make_item(OP_APPEND, 64'h4200_0000_0000_0000, 4'd1, 64'sd6));
    send_item(make_item(OP_LOOKUP, 64'h4200_0000_0000_0000, 4'd1, '0));
    send_item(make_item(OP_LOOKUP, 64'h4D00_0000_0000_0000, 4'd1, '0));
    wait_for_results();
  endtask

  // Fill all entries in order, push appends into the full table, and run
  // full-depth searches.
  task automatic test_table_full();
    logic [63:0] full_keys [TABLE_DEPTH];
    int unsigned full_lens [TABLE_DEPTH];
    logic [63:0] k;
    int unsigned l;
    int unsigned j;
    send_item(make_item(OP_CLEAR, rand_key(), length_code(KEY_BYTES), rand_loc()));
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      // The first two bytes carry the index, so the keys ascend and differ.
      l            = $urandom_range(2, KEY_BYTES);
      full_keys[i] = {16'(i), $urandom(), 16'($urandom())} & byte_mask(l);
      full_lens[i] = l;
      send_item(make_item(OP_APPEND, with_stray(full_keys[i], l), length_code(l), rand_loc()));
    end
    send_item(make_item(OP_APPEND, rand_key(), 4'd8, LOC_MAX));
    send_item(make_item(OP_APPEND, rand_key(), 4'd0, LOC_MIN));
    for (int n = 0; n < 48; n++) begin
      j = $urandom_range(0, TABLE_DEPTH - 1);
      k = full_keys[j];
      l = full_lens[j];
      case ($urandom_range(0, 3))
        0, 1: ;
        2: begin
          // Near miss: one byte longer, or the last byte bumped.
          if (l < KEY_BYTES) begin
            l++;
          end else begin
            k[7:0] = k[7:0] + 8'd1;
          end
        end
        default: begin
          // Beyond either end of the table.
          if ($urandom_range(0, 1) == 0) begin
            k = 64'd0;
            l = 1;
          end else begin
            k = {64{1'b1}};
            l = KEY_BYTES;
          end
        end
      endcase
      send_item(make_item(OP_LOOKUP, with_stray(k, l), length_code(l), rand_loc()));
    end
    wait_for_results();
  endtask

  // Sessions of clear, sorted appends with random content, then lookups that
  // mostly hit, with a sprinkle of noise transactions in between.
  task automatic test_random_sessions(input int unsigned item_budget);
    logic [63:0] keys[$];
    int unsigned lens[$];
    logic [63:0] k;
    int unsigned l;
    int unsigned n;
    int unsigned pos;
    int unsigned j;
    int unsigned stop_at;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      keys.delete();
      lens.delete();
      send_item(make_item(OP_CLEAR, rand_key(), 4'($urandom_range(0, LEN_MAX)), rand_loc()));
      // Draw the session's keys and keep them sorted by insertion.
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      for (int unsigned i = 0; i < n; i++) begin
        l   = $urandom_range(0, KEY_BYTES);
        k   = rand_key() & byte_mask(l);
        pos = keys.size();
        while (pos > 0 && key_compare(k, l, keys[pos-1], lens[pos-1]) < 0) pos--;
        keys.insert(pos, k);
        lens.insert(pos, l);
      end
      foreach (keys[i]) begin
        maybe_noise();
        send_item(make_item(OP_APPEND, with_stray(keys[i], lens[i]),
                            length_code(lens[i]), rand_loc()));
      end
      n = $urandom_range(4, 16);
      for (int unsigned i = 0; i < n; i++) begin
        maybe_noise();
        k = rand_key();
        l = $urandom_range(0, KEY_BYTES);
        if (keys.size() != 0) begin
          j = $urandom_range(0, keys.size() - 1);
          case ($urandom_range(0, 3))
            0, 1: begin
              k = keys[j];
              l = lens[j];
            end
            2: begin
              // Near miss: bump the last byte, or grow or shrink the key.
              k = keys[j];
              l = lens[j];
              if (l != 0 && $urandom_range(0, 1) == 0) begin
                k[63-8*(l-1) -: 8] = k[63-8*(l-1) -: 8] +
                                     (($urandom_range(0, 1) == 0) ? 8'h01 : 8'hFF);
              end else if (l < KEY_BYTES) begin
                l++;
              end else begin
                l--;
              end
            end
            default: ;
          endcase
        end
        send_item(make_item(OP_LOOKUP, with_stray(k, l), length_code(l), rand_loc()));
      end
      // Now and then let the block drain completely before the next session.
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender idles a little, receiver stalls a lot.
    send_idle_pct  = 32;
    recv_stall_pct = 83;
    test_directed_cases();
    test_random_sessions(200);

    // Phase two: the other way round.
    send_idle_pct  = 83;
    recv_stall_pct = 32;
    test_table_full();
    test_random_sessions(200);

    // Phase three: back to back on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sessions(200);

    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    // Catch any stray result that trails the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions: %0d appends, %0d refused as full, %0d clears, %0d unused op",
             items_sent, n_append_ok, n_full, n_clear, n_unused);
    $display("Lookups %0d with %0d hits; %0d results checked, %0d mismatches",
             n_lookup, n_hit, n_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sks_pkg.sv
rtl/core/sks_entry_ram.sv
rtl/core/sks_key_cmp.sv
rtl/core/sorted_key_index_search.sv
tb/tb_sorted_key_index_search.sv
